// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by sorted_sparse_triple_store.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/sst_pkg.sv -----
// ---------------------------------------------------------------------------
// sst_pkg
// Types, constants and codes of the sorted sparse triple store.
// ---------------------------------------------------------------------------
package sst_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = 16;
    localparam int VAL_W  = 64;
    localparam int CFG_W  = 17;

    localparam logic [VAL_W-1:0] FP_ZERO     = 64'h0000_0000_0000_0000;
    localparam logic [VAL_W-1:0] FP_DEF_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [VAL_W-1:0] FP_QUIET    = 64'h0008_0000_0000_0000;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_ACCUM   = 3'd1,
        CMD_GET     = 3'd2,
        CMD_SET_ALL = 3'd3,
        CMD_RESTART = 3'd4,
        CMD_NEXT    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_COLUMN_MAJOR = 2'd0,
        CFG_NUM_ROWS     = 2'd1,
        CFG_NUM_COLS     = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_READ,
        S_ADD,
        S_APPLY
    } state_t;

    typedef enum logic [2:0] {
        FA_IDLE,
        FA_LOAD,
        FA_ADD,
        FA_NORM,
        FA_ROUND
    } fa_state_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [VAL_W-1:0] value_in;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic [IDX_W-1:0] row_out;
        logic [IDX_W-1:0] col_out;
        logic             found;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } out_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              capture;
        logic              lookup;
        logic              ins;
        logic              upd;
        logic              set_all;
        logic              column_major;
        logic [CNT_W-1:0]  count;
        logic              rd_ok;
        logic [ADDR_W-1:0] rd_pos;
        logic [IDX_W-1:0]  key_row;
        logic [IDX_W-1:0]  key_col;
        logic [VAL_W-1:0]  wr_val;
    } ctl_t;

endpackage

// ----- src/sst_cell.sv -----
// ---------------------------------------------------------------------------
// sst_cell
// One table slot: holds an entry, compares it against the broadcast key and
// takes its left neighbor's entry when an insert shifts the tail.
// ---------------------------------------------------------------------------
module sst_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sst_pkg::ctl_t             ctl,
    input  logic [sst_pkg::ADDR_W-1:0] idx,
    input  logic [sst_pkg::IDX_W-1:0] prev_row,
    input  logic [sst_pkg::IDX_W-1:0] prev_col,
    input  logic [sst_pkg::VAL_W-1:0] prev_val,
    input  logic                      prev_gt,
    output logic [sst_pkg::IDX_W-1:0] row,
    output logic [sst_pkg::IDX_W-1:0] col,
    output logic [sst_pkg::VAL_W-1:0] val,
    output logic                      gt,
    output logic                      eq,
    output logic                      sel
);

    logic [sst_pkg::IDX_W-1:0]   row_reg;
    logic [sst_pkg::IDX_W-1:0]   col_reg;
    logic [sst_pkg::VAL_W-1:0]   val_reg;
    logic                        gt_reg, eq_reg, sel_reg;
    logic                        occ;
    logic                        at_end;
    logic [2*sst_pkg::IDX_W-1:0] key_mine, key_req;
    logic                        gt_now, eq_now;

    assign occ    = {1'b0, idx} < ctl.count;
    assign at_end = {1'b0, idx} == ctl.count;

    always_comb
    begin
        if (ctl.column_major)
        begin
            key_mine = {col_reg, row_reg};
            key_req  = {ctl.key_col, ctl.key_row};
        end
        else
        begin
            key_mine = {row_reg, col_reg};
            key_req  = {ctl.key_row, ctl.key_col};
        end
        gt_now = occ && (key_mine > key_req);
        eq_now = occ && (key_mine == key_req);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            gt_reg  <= gt_now;
            eq_reg  <= eq_now;
            sel_reg <= ctl.lookup ? eq_now : (ctl.rd_ok && (idx == ctl.rd_pos));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            if (prev_gt)
            begin
                row_reg <= prev_row;
                col_reg <= prev_col;
                val_reg <= prev_val;
            end
            else if (gt_reg || at_end)
            begin
                row_reg <= ctl.key_row;
                col_reg <= ctl.key_col;
                val_reg <= ctl.wr_val;
            end
        end
        else if (ctl.set_all || (ctl.upd && eq_reg))
        begin
            val_reg <= ctl.wr_val;
        end
    end

    assign row = row_reg;
    assign col = col_reg;
    assign val = val_reg;
    assign gt  = gt_reg;
    assign eq  = eq_reg;
    assign sel = sel_reg;

endmodule

// ----- src/sst_fpadd.sv -----
// ---------------------------------------------------------------------------
// sst_fpadd
// Multi-cycle IEEE-754 double adder, round to nearest even, with an
// iterative normalizing shifter.
// ---------------------------------------------------------------------------
module sst_fpadd (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sst_pkg::VAL_W-1:0] a,
    input  logic [sst_pkg::VAL_W-1:0] b,
    output logic                      done,
    output logic [sst_pkg::VAL_W-1:0] sum
);

    sst_pkg::fa_state_t st_reg, st_next;

    logic [63:0] a_reg, b_reg;
    logic        spec_reg;
    logic [63:0] spec_val_reg;
    logic        sign_reg, sub_reg;
    logic [11:0] e_reg;
    logic [55:0] ma_reg, mb_reg;
    logic [56:0] m_reg;
    logic        zero_reg;
    logic        done_reg;
    logic [63:0] sum_reg;

    // unpack / align
    logic        a_nan, b_nan, a_inf, b_inf, a_big;
    logic [63:0] big, lesser;
    logic [10:0] e_big, e_small, d;
    logic [55:0] x_big, x_small, x_shift;
    logic        sticky;
    // add
    logic [56:0] m_sum;
    // normalize
    logic        norm_done;
    // round
    logic [53:0] r_sum;
    logic [52:0] mant_f;
    logic [11:0] e_f;
    logic        up;
    logic [63:0] r_res;

    always_comb
    begin
        a_nan = (a_reg[62:52] == 11'h7FF) && (a_reg[51:0] != 52'd0);
        b_nan = (b_reg[62:52] == 11'h7FF) && (b_reg[51:0] != 52'd0);
        a_inf = (a_reg[62:52] == 11'h7FF) && (a_reg[51:0] == 52'd0);
        b_inf = (b_reg[62:52] == 11'h7FF) && (b_reg[51:0] == 52'd0);
        a_big = a_reg[62:0] >= b_reg[62:0];
        big    = a_big ? a_reg : b_reg;
        lesser = a_big ? b_reg : a_reg;
        e_big   = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        e_small = (lesser[62:52] == 11'd0) ? 11'd1 : lesser[62:52];
        d       = e_big - e_small;
        x_big   = {big[62:52] != 11'd0, big[51:0], 3'b000};
        x_small = {lesser[62:52] != 11'd0, lesser[51:0], 3'b000};
        if (d >= 11'd56)
        begin
            x_shift = 56'd0;
            sticky  = |x_small;
        end
        else
        begin
            x_shift = x_small >> d[5:0];
            sticky  = |(x_small & ((56'd1 << d[5:0]) - 56'd1));
        end
    end

    assign m_sum = sub_reg ? ({1'b0, ma_reg} - {1'b0, mb_reg})
                           : ({1'b0, ma_reg} + {1'b0, mb_reg});

    assign norm_done = m_reg[55] || (e_reg <= 12'd1);

    always_comb
    begin
        up     = m_reg[2] && (m_reg[1] || m_reg[0] || m_reg[3]);
        r_sum  = {1'b0, m_reg[55:3]} + {53'd0, up};
        if (r_sum[53])
        begin
            mant_f = r_sum[53:1];
            e_f    = e_reg + 12'd1;
        end
        else
        begin
            mant_f = r_sum[52:0];
            e_f    = e_reg;
        end
        if (mant_f[52] && (e_f >= 12'd2047))
            r_res = {sign_reg, 11'h7FF, 52'd0};
        else
            r_res = {sign_reg, (mant_f[52] ? e_f[10:0] : 11'd0), mant_f[51:0]};
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            sst_pkg::FA_IDLE:  if (start) st_next = sst_pkg::FA_LOAD;
            sst_pkg::FA_LOAD:  st_next = sst_pkg::FA_ADD;
            sst_pkg::FA_ADD:   st_next = sst_pkg::FA_NORM;
            sst_pkg::FA_NORM:  if (spec_reg || zero_reg || norm_done) st_next = sst_pkg::FA_ROUND;
            sst_pkg::FA_ROUND: st_next = sst_pkg::FA_IDLE;
            default:           st_next = sst_pkg::FA_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= sst_pkg::FA_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == sst_pkg::FA_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            sst_pkg::FA_IDLE:
            begin
                if (start)
                begin
                    a_reg <= a;
                    b_reg <= b;
                end
            end
            sst_pkg::FA_LOAD:
            begin
                spec_reg <= 1'b1;
                if (a_nan)
                    spec_val_reg <= a_reg | sst_pkg::FP_QUIET;
                else if (b_nan)
                    spec_val_reg <= b_reg | sst_pkg::FP_QUIET;
                else if (a_inf && b_inf && (a_reg[63] != b_reg[63]))
                    spec_val_reg <= sst_pkg::FP_DEF_NAN;
                else if (a_inf)
                    spec_val_reg <= a_reg;
                else if (b_inf)
                    spec_val_reg <= b_reg;
                else
                    spec_reg <= 1'b0;
                sign_reg <= big[63];
                sub_reg  <= a_reg[63] != b_reg[63];
                e_reg    <= {1'b0, e_big};
                ma_reg   <= x_big;
                mb_reg   <= x_shift | {55'd0, sticky};
            end
            sst_pkg::FA_ADD:
            begin
                zero_reg <= (m_sum == 57'd0);
                if (m_sum == 57'd0)
                    sign_reg <= sub_reg ? 1'b0 : sign_reg;
                if (m_sum[56])
                begin
                    m_reg <= {1'b0, m_sum[56:2], m_sum[1] | m_sum[0]};
                    e_reg <= e_reg + 12'd1;
                end
                else
                    m_reg <= m_sum;
            end
            sst_pkg::FA_NORM:
            begin
                if (!norm_done)
                begin
                    if ((m_reg[55:40] == 16'd0) && (e_reg > 12'd16))
                    begin
                        m_reg <= {m_reg[40:0], 16'd0};
                        e_reg <= e_reg - 12'd16;
                    end
                    else
                    begin
                        m_reg <= {m_reg[55:0], 1'b0};
                        e_reg <= e_reg - 12'd1;
                    end
                end
            end
            sst_pkg::FA_ROUND:
            begin
                if (spec_reg)
                    sum_reg <= spec_val_reg;
                else if (zero_reg)
                    sum_reg <= {sign_reg, 63'd0};
                else
                    sum_reg <= r_res;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ----- src/sorted_sparse_triple_store.sv -----
// ---------------------------------------------------------------------------
// sorted_sparse_triple_store
// Sorted table of (row, column, FP64 value) entries held in a chain of cells.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_ready   sst_pkg::in_t
//   rsp      out  rsp_valid / rsp_ready   sst_pkg::out_t
//   cfg      in   cfg_we                  cfg_index, cfg_data
//
// Every command steps through accept, key match in all cells, result bus
// read and apply. An accumulate that hits an entry also waits on the double
// adder, whose normalize loop sets how long it runs. No clearing pass after
// reset. A stalled response holds the apply step; the next request is taken
// as soon as the response sits in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_sparse_triple_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  sst_pkg::in_t                req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output sst_pkg::out_t               rsp,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [sst_pkg::CFG_W-1:0]   cfg_data
);

    localparam int DEPTH  = sst_pkg::DEPTH;
    localparam int CNT_W  = sst_pkg::CNT_W;
    localparam int ADDR_W = sst_pkg::ADDR_W;
    localparam int IDX_W  = sst_pkg::IDX_W;
    localparam int VAL_W  = sst_pkg::VAL_W;

    sst_pkg::state_t state_reg, state_next;
    sst_pkg::in_t    req_reg;
    sst_pkg::out_t   rsp_reg, res;
    sst_pkg::ctl_t   ctl;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rem_reg;
    logic                     cm_reg;
    logic [sst_pkg::CFG_W-1:0] nrows_reg, ncols_reg;
    logic                     bad_reg, rd_ok_reg, hit_reg;
    logic                     rsp_valid_reg;
    logic [VAL_W-1:0]         bus_val_reg, sum_reg;
    logic [IDX_W-1:0]         bus_row_reg, bus_col_reg;

    logic [IDX_W-1:0] c_row [DEPTH];
    logic [IDX_W-1:0] c_col [DEPTH];
    logic [VAL_W-1:0] c_val [DEPTH];
    logic [DEPTH-1:0] c_gt, c_eq, c_sel;

    logic [VAL_W-1:0] bus_val;
    logic [IDX_W-1:0] bus_row, bus_col;

    logic             rd_go;
    logic [CNT_W-1:0] rd_nrem;
    logic             rd_ok;
    logic             bad_now;
    logic             is_key_cmd, is_acc_hit;
    logic             fire;
    logic             do_ins, do_upd, do_all, do_restart;
    logic [VAL_W-1:0] wr_val;
    logic             add_start, add_done;
    logic [VAL_W-1:0] add_sum;

    // ---------------- cell chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                sst_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl),
                    .idx      (ADDR_W'(gi)),
                    .prev_row ({IDX_W{1'b0}}),
                    .prev_col ({IDX_W{1'b0}}),
                    .prev_val ({VAL_W{1'b0}}),
                    .prev_gt  (1'b0),
                    .row      (c_row[gi]),
                    .col      (c_col[gi]),
                    .val      (c_val[gi]),
                    .gt       (c_gt[gi]),
                    .eq       (c_eq[gi]),
                    .sel      (c_sel[gi])
                );
            end
            else
            begin : g_body
                sst_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl),
                    .idx      (ADDR_W'(gi)),
                    .prev_row (c_row[gi-1]),
                    .prev_col (c_col[gi-1]),
                    .prev_val (c_val[gi-1]),
                    .prev_gt  (c_gt[gi-1]),
                    .row      (c_row[gi]),
                    .col      (c_col[gi]),
                    .val      (c_val[gi]),
                    .gt       (c_gt[gi]),
                    .eq       (c_eq[gi]),
                    .sel      (c_sel[gi])
                );
            end
        end
    endgenerate

    // at most one cell is selected
    always_comb
    begin
        bus_val = '0;
        bus_row = '0;
        bus_col = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (c_sel[i])
            begin
                bus_val = bus_val | c_val[i];
                bus_row = bus_row | c_row[i];
                bus_col = bus_col | c_col[i];
            end
        end
    end

    sst_fpadd u_fpadd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (bus_val),
        .b     (req_reg.value_in),
        .done  (add_done),
        .sum   (add_sum)
    );

    // ---------------- readout position ----------------
    assign rd_go   = rem_reg != '0;
    assign rd_nrem = rem_reg - CNT_W'(1);
    assign rd_ok   = rd_go && (rd_nrem < count_reg);

    assign bad_now = ({1'b0, req_reg.row_index} >= nrows_reg)
                  || ({1'b0, req_reg.col_index} >= ncols_reg);

    assign is_key_cmd = (req_reg.cmd == sst_pkg::CMD_INSERT)
                     || (req_reg.cmd == sst_pkg::CMD_ACCUM)
                     || (req_reg.cmd == sst_pkg::CMD_GET);
    assign is_acc_hit = (req_reg.cmd == sst_pkg::CMD_ACCUM) && !bad_reg && (|c_eq);

    assign fire = (state_reg == sst_pkg::S_APPLY) && (!rsp_valid_reg || rsp_ready);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::S_IDLE:  if (req_valid) state_next = sst_pkg::S_MATCH;
            sst_pkg::S_MATCH: state_next = sst_pkg::S_READ;
            sst_pkg::S_READ:  state_next = is_acc_hit ? sst_pkg::S_ADD : sst_pkg::S_APPLY;
            sst_pkg::S_ADD:   if (add_done) state_next = sst_pkg::S_APPLY;
            sst_pkg::S_APPLY: if (fire) state_next = sst_pkg::S_IDLE;
            default:          state_next = sst_pkg::S_IDLE;
        endcase
    end

    // ---------------- command outcome ----------------
    always_comb
    begin
        res         = '0;
        count_next  = count_reg;
        do_ins      = 1'b0;
        do_upd      = 1'b0;
        do_all      = 1'b0;
        do_restart  = 1'b0;
        wr_val      = req_reg.value_in;
        case (req_reg.cmd)
            sst_pkg::CMD_INSERT, sst_pkg::CMD_ACCUM:
            begin
                if (bad_reg)
                    res.status = sst_pkg::ST_RANGE;
                else if (hit_reg)
                begin
                    if (req_reg.cmd == sst_pkg::CMD_ACCUM)
                        wr_val = sum_reg;
                    do_upd        = 1'b1;
                    res.value_out = wr_val;
                end
                else if (count_reg >= CNT_W'(DEPTH))
                    res.status = sst_pkg::ST_FULL;
                else
                begin
                    do_ins        = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    res.value_out = wr_val;
                end
            end
            sst_pkg::CMD_GET:
            begin
                if (bad_reg)
                    res.status = sst_pkg::ST_RANGE;
                else if (hit_reg)
                begin
                    res.found     = 1'b1;
                    res.value_out = bus_val_reg;
                end
            end
            sst_pkg::CMD_SET_ALL: do_all     = 1'b1;
            sst_pkg::CMD_RESTART: do_restart = 1'b1;
            sst_pkg::CMD_NEXT:
            begin
                if (rd_ok_reg)
                begin
                    res.found     = 1'b1;
                    res.value_out = bus_val_reg;
                    res.row_out   = bus_row_reg;
                    res.col_out   = bus_col_reg;
                end
            end
            default: ;
        endcase
        res.entry_count = count_next;
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        ctl              = '0;
        ctl.capture      = state_reg == sst_pkg::S_MATCH;
        ctl.lookup       = is_key_cmd;
        ctl.ins          = fire && do_ins;
        ctl.upd          = fire && do_upd;
        ctl.set_all      = fire && do_all;
        ctl.column_major = cm_reg;
        ctl.count        = count_reg;
        ctl.rd_ok        = (req_reg.cmd == sst_pkg::CMD_NEXT) && rd_ok;
        ctl.rd_pos       = ADDR_W'(count_reg - CNT_W'(1) - rd_nrem);
        ctl.key_row      = req_reg.row_index;
        ctl.key_col      = req_reg.col_index;
        ctl.wr_val       = wr_val;
        add_start        = (state_reg == sst_pkg::S_READ) && is_acc_hit;
        req_ready        = state_reg == sst_pkg::S_IDLE;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            cm_reg        <= 1'b1;
            nrows_reg     <= sst_pkg::CFG_W'(65536);
            ncols_reg     <= sst_pkg::CFG_W'(65536);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sst_pkg::CFG_COLUMN_MAJOR: if (count_reg == '0) cm_reg <= cfg_data[0];
                    sst_pkg::CFG_NUM_ROWS:     nrows_reg <= cfg_data;
                    sst_pkg::CFG_NUM_COLS:     ncols_reg <= cfg_data;
                    default: ;
                endcase
            end
            if ((state_reg == sst_pkg::S_MATCH) && (req_reg.cmd == sst_pkg::CMD_NEXT) && rd_go)
                rem_reg <= rd_nrem;
            if (fire)
            begin
                count_reg <= count_next;
                if (do_restart)
                    rem_reg <= count_reg;
            end
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (state_reg == sst_pkg::S_MATCH)
        begin
            bad_reg   <= bad_now;
            rd_ok_reg <= rd_ok;
        end
        if (state_reg == sst_pkg::S_READ)
        begin
            hit_reg     <= |c_eq;
            bus_val_reg <= bus_val;
            bus_row_reg <= bus_row;
            bus_col_reg <= bus_col;
        end
        if (add_done)
            sum_reg <= add_sum;
        if (fire)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    `SST_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `SST_ASSERT(a_sel_onehot, clk, rst_n, $onehot0(c_sel))
    `SST_ASSERT(a_add_only_busy, clk, rst_n, !add_done || (state_reg == sst_pkg::S_ADD))
    `SST_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1)))

endmodule
